### hdl/aae16_pkg.sv
// ----------------------------------------------------------------------------
// aae16_pkg
// Shared types and constants for the adaptive 16-bit arithmetic encoder.
// ----------------------------------------------------------------------------
package aae16_pkg;

    localparam int C_MAX_RES = 40;
    localparam int C_OCNT_W = 6;

    localparam logic [15:0] C_HALF = 16'h8000;
    localparam logic [15:0] C_QUARTER = 16'h4000;
    localparam logic [15:0] C_LOW_MASK = 16'h3FFF;
    localparam logic [15:0] C_TOP = 16'hFFFF;
    localparam logic [14:0] C_TOTAL_LIMIT = 15'h3FFF;
    localparam logic [6:0] C_INC_RESET = 7'd10;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic restart;
        logic rd_sym;
        logic rd_sym1;
        logic cap_lo;
        logic cap_hi;
        logic mul_hi;
        logic mul_lo;
        logic save_qh;
        logic div_step;
        logic set_range;
        logic shift_step;
        logic pend_step;
        logic flush_bit;
        logic flush_end;
        logic pass_init;
        logic pass_halve;
        logic pass_run;
        logic out_rd;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic settle;
        logic straddle;
        logic pend_zero;
        logic pend_last;
        logic pass_done;
        logic need_halve;
        logic out_last;
        logic ocnt_zero;
    } t_stat;

endpackage

### hdl/aae16_if.sv
// ----------------------------------------------------------------------------
// aae16 channel interfaces
// Valid/ready channels for symbols, coded bytes and the increment register.
// ----------------------------------------------------------------------------
interface aae16_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] symbol;
    modport source (output valid, output mode, output symbol, input ready);
    modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface aae16_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       stream_end;
    logic       underflow_saturated;
    modport source (output valid, output out_byte, output last, output stream_end,
                    output underflow_saturated, input ready);
    modport sink (input valid, input out_byte, input last, input stream_end,
                  input underflow_saturated, output ready);
endinterface

interface aae16_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] count_increment;
    modport source (output valid, output count_increment, input ready);
    modport sink (input valid, input count_increment, output ready);
endinterface

### hdl/aae16_dp.sv
// ----------------------------------------------------------------------------
// aae16_dp
// Datapath: count table, interval bounds, divider, bit packer, byte buffer.
// ----------------------------------------------------------------------------
module aae16_dp #(
    parameter int SYMBOL_COUNT = 256,
    parameter int UNDERFLOW_CAP = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aae16_pkg::t_cmd   i_cmd,
    output aae16_pkg::t_stat  o_stat,
    input  logic [7:0]        i_symbol,
    input  logic              i_cfg_valid,
    input  logic [6:0]        i_cfg_data,
    output logic [7:0]        o_out_byte,
    output logic              o_sat
);
    import aae16_pkg::*;

    localparam int AW = $clog2(SYMBOL_COUNT + 1);
    localparam int CW = $clog2(SYMBOL_COUNT + 2);
    localparam logic [CW-1:0] LastIdx = CW'(SYMBOL_COUNT);
    localparam logic [AW-1:0] LastAddr = AW'(SYMBOL_COUNT);
    localparam logic [8:0] SymCount = 9'(SYMBOL_COUNT);
    localparam logic [7:0] SymMax = 8'(SYMBOL_COUNT - 1);
    localparam logic [7:0] PendCap = 8'(UNDERFLOW_CAP);
    localparam logic [14:0] TotalReset = 15'(SYMBOL_COUNT);
    localparam logic [C_OCNT_W-1:0] MaxRes = C_OCNT_W'(C_MAX_RES);

    logic [14:0] tbl [0:SYMBOL_COUNT];
    logic [7:0]  omem [0:C_MAX_RES-1];

    logic [6:0]  r_inc;
    logic [7:0]  r_sym;
    logic [15:0] r_low, r_high;
    logic [7:0]  r_pend;
    logic [2:0]  r_bpos;
    logic [7:0]  r_bbuf;
    logic [14:0] r_total;
    logic [14:0] r_lo, r_hi;
    logic [31:0] r_dvd;
    logic [14:0] r_rem;
    logic [4:0]  r_dcnt;
    logic [15:0] r_qh;
    logic        r_pbit;
    logic        r_sat;
    logic [CW-1:0] r_j;
    logic [AW-1:0] r_wa;
    logic        r_wv;
    logic [14:0] r_prev;
    logic        r_halve;
    logic [C_OCNT_W-1:0] r_ocnt, r_oidx;
    logic [7:0]  r_obyte;
    logic [14:0] r_rd;

    logic [16:0] span;
    logic [14:0] divisor;
    logic [15:0] dtrial;
    logic        dge;
    logic        settle, straddle;
    logic        pb_en, pb_bit;
    logic [7:0]  n_bbuf;
    logic        om_we;
    logic [7:0]  om_data;
    logic        issue;
    logic [14:0] halved, pass_v;
    logic        rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [14:0] wr_data;
    logic        bump;

    assign span = {1'b0, r_high} - {1'b0, r_low} + 17'd1;
    assign divisor = (r_total == 15'd0) ? 15'd1 : r_total;
    assign dtrial = {r_rem, r_dvd[31]};
    assign dge = dtrial >= {1'b0, divisor};

    assign settle = r_high[15] == r_low[15];
    assign straddle = r_low[14] & ~r_high[14];

    // bit packer input
    always_comb begin
        pb_en = 1'b0;
        pb_bit = 1'b0;
        if (i_cmd.shift_step && settle) begin
            pb_en = 1'b1;
            pb_bit = r_high[15];
        end else if (i_cmd.pend_step) begin
            pb_en = 1'b1;
            pb_bit = r_pbit;
        end else if (i_cmd.flush_bit) begin
            pb_en = 1'b1;
            pb_bit = r_low[14];
        end
    end

    assign n_bbuf = r_bbuf | (8'(pb_bit) << r_bpos);
    assign om_we = ((pb_en && r_bpos == 3'd7) || (i_cmd.flush_end && r_bpos != 3'd0))
                   && (r_ocnt < MaxRes);
    assign om_data = pb_en ? n_bbuf : r_bbuf;
    assign bump = (i_cmd.shift_step && !settle && straddle) || i_cmd.flush_bit;

    assign issue = r_j <= LastIdx;
    assign halved = (r_rd >> 1) <= r_prev ? r_prev + 15'd1 : r_rd >> 1;
    assign pass_v = r_halve ? halved : r_rd + 15'(r_inc);

    always_comb begin
        rd_addr = r_j[AW-1:0];
        if (i_cmd.rd_sym) begin
            rd_addr = AW'(r_sym);
        end else if (i_cmd.rd_sym1) begin
            rd_addr = AW'({1'b0, r_sym} + 9'd1);
        end
    end
    assign rd_en = i_cmd.rd_sym | i_cmd.rd_sym1 | (i_cmd.pass_run & issue);
    assign wr_en = i_cmd.clear_step | (i_cmd.pass_run & r_wv);
    assign wr_addr = i_cmd.clear_step ? r_j[AW-1:0] : r_wa;
    assign wr_data = i_cmd.clear_step ? 15'(r_j) : pass_v;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tbl[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= tbl[rd_addr];
        end
        if (om_we) begin
            omem[r_ocnt] <= om_data;
        end
        if (i_cmd.out_rd) begin
            r_obyte <= omem[r_oidx];
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym <= ({1'b0, i_symbol} >= SymCount) ? SymMax : i_symbol;
        end
        if (i_cmd.cap_lo) begin
            r_lo <= r_rd;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rd;
        end
        if (i_cmd.mul_hi || i_cmd.mul_lo) begin
            r_dvd <= {15'd0, span} * {17'd0, (i_cmd.mul_hi ? r_hi : r_lo)};
            r_rem <= 15'd0;
            r_dcnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_rem <= dge ? 15'(dtrial - {1'b0, divisor}) : dtrial[14:0];
            r_dvd <= {r_dvd[30:0], dge};
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (i_cmd.save_qh) begin
            r_qh <= r_dvd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= C_INC_RESET;
            r_low <= 16'd0;
            r_high <= C_TOP;
            r_pend <= 8'd0;
            r_bpos <= 3'd0;
            r_bbuf <= 8'd0;
            r_total <= TotalReset;
            r_j <= '0;
            r_wv <= 1'b0;
            r_sat <= 1'b0;
            r_ocnt <= '0;
            r_oidx <= '0;
            r_pbit <= 1'b0;
            r_prev <= 15'd0;
            r_halve <= 1'b0;
            r_wa <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_inc <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_sat <= 1'b0;
                r_ocnt <= '0;
                r_oidx <= '0;
            end
            if (om_we) begin
                r_ocnt <= r_ocnt + 1'b1;
            end
            if (i_cmd.out_next) begin
                r_oidx <= r_oidx + 1'b1;
            end
            if (pb_en) begin
                r_bbuf <= (r_bpos == 3'd7) ? 8'd0 : n_bbuf;
                r_bpos <= r_bpos + 3'd1;
            end
            if (bump) begin
                if (r_pend >= PendCap) begin
                    r_pend <= PendCap;
                    r_sat <= 1'b1;
                end else begin
                    r_pend <= r_pend + 8'd1;
                end
            end
            if (i_cmd.pend_step) begin
                r_pend <= r_pend - 8'd1;
            end
            if (i_cmd.flush_bit) begin
                r_pbit <= ~r_low[14];
            end
            if (i_cmd.set_range) begin
                r_high <= r_low + r_qh - 16'd1;
                r_low <= r_low + r_dvd[15:0];
            end
            if (i_cmd.shift_step) begin
                if (settle) begin
                    r_pbit <= ~r_high[15];
                    r_low <= r_low << 1;
                    r_high <= (r_high << 1) | 16'd1;
                end else if (straddle) begin
                    r_low <= (r_low & C_LOW_MASK) << 1;
                    r_high <= ((r_high | C_QUARTER) << 1) | 16'd1;
                end
            end
            if (i_cmd.clear_step) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.pass_run) begin
                r_wv <= issue;
                if (issue) begin
                    r_j <= r_j + 1'b1;
                    r_wa <= r_j[AW-1:0];
                end
                if (r_wv) begin
                    r_prev <= pass_v;
                    if (r_wa == LastAddr) begin
                        r_total <= pass_v;
                    end
                end
            end
            if (i_cmd.pass_init) begin
                r_j <= i_cmd.pass_halve ? CW'(1) : CW'(r_sym) + CW'(1);
                r_wv <= 1'b0;
                r_prev <= 15'd0;
                r_halve <= i_cmd.pass_halve;
            end
            if (i_cmd.restart) begin
                r_low <= 16'd0;
                r_high <= C_TOP;
                r_pend <= 8'd0;
                r_bpos <= 3'd0;
                r_bbuf <= 8'd0;
                r_total <= TotalReset;
                r_j <= '0;
                r_wv <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.clear_done = r_j == LastIdx;
        o_stat.div_done = r_dcnt == 5'd31;
        o_stat.settle = settle;
        o_stat.straddle = straddle;
        o_stat.pend_zero = r_pend == 8'd0;
        o_stat.pend_last = r_pend == 8'd1;
        o_stat.pass_done = r_wv && (r_wa == LastAddr);
        o_stat.need_halve = pass_v >= C_TOTAL_LIMIT;
        o_stat.out_last = (r_oidx + 1'b1) == r_ocnt;
        o_stat.ocnt_zero = r_ocnt == '0;
    end

    assign o_out_byte = r_obyte;
    assign o_sat = r_sat;

endmodule

### hdl/aae16_ctrl.sv
// ----------------------------------------------------------------------------
// aae16_ctrl
// Sequencer: steps the datapath through clear, lookup, divide, shift, update, flush, drain.
// ----------------------------------------------------------------------------
module aae16_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_stream_end,
    output aae16_pkg::t_cmd   o_cmd,
    input  aae16_pkg::t_stat  i_stat
);
    import aae16_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RD_LO    = 5'd2;
    localparam logic [4:0] S_RD_HI    = 5'd3;
    localparam logic [4:0] S_CAP_HI   = 5'd4;
    localparam logic [4:0] S_MUL_HI   = 5'd5;
    localparam logic [4:0] S_DIV_HI   = 5'd6;
    localparam logic [4:0] S_MUL_LO   = 5'd7;
    localparam logic [4:0] S_DIV_LO   = 5'd8;
    localparam logic [4:0] S_SET      = 5'd9;
    localparam logic [4:0] S_SHIFT    = 5'd10;
    localparam logic [4:0] S_PEND     = 5'd11;
    localparam logic [4:0] S_FLUSH    = 5'd12;
    localparam logic [4:0] S_FL_END   = 5'd13;
    localparam logic [4:0] S_INC      = 5'd14;
    localparam logic [4:0] S_HALVE    = 5'd15;
    localparam logic [4:0] S_OUT_RD   = 5'd16;
    localparam logic [4:0] S_OUT_WAIT = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_mode = i_mode;
                    n_state = i_mode ? S_FLUSH : S_RD_LO;
                end
            end
            S_RD_LO: begin
                o_cmd.rd_sym = 1'b1;
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_sym1 = 1'b1;
                o_cmd.cap_lo = 1'b1;
                n_state = S_CAP_HI;
            end
            S_CAP_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_DIV_HI;
            end
            S_DIV_HI: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.save_qh = 1'b1;
                o_cmd.mul_lo = 1'b1;
                n_state = S_DIV_LO;
            end
            S_DIV_LO: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                o_cmd.set_range = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.settle) begin
                    n_state = i_stat.pend_zero ? S_SHIFT : S_PEND;
                end else if (!i_stat.straddle) begin
                    // no shift left to make: start the count update
                    o_cmd.pass_init = 1'b1;
                    n_state = S_INC;
                end
            end
            S_PEND: begin
                o_cmd.pend_step = 1'b1;
                if (i_stat.pend_last) begin
                    n_state = r_mode ? S_FL_END : S_SHIFT;
                end
            end
            S_FLUSH: begin
                o_cmd.flush_bit = 1'b1;
                n_state = S_PEND;
            end
            S_FL_END: begin
                o_cmd.flush_end = 1'b1;
                n_state = S_OUT_RD;
            end
            S_INC: begin
                o_cmd.pass_run = 1'b1;
                if (i_stat.pass_done) begin
                    if (i_stat.need_halve) begin
                        o_cmd.pass_init = 1'b1;
                        o_cmd.pass_halve = 1'b1;
                        n_state = S_HALVE;
                    end else begin
                        n_state = i_stat.ocnt_zero ? S_IDLE : S_OUT_RD;
                    end
                end
            end
            S_HALVE: begin
                o_cmd.pass_run = 1'b1;
                if (i_stat.pass_done) begin
                    n_state = i_stat.ocnt_zero ? S_IDLE : S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    if (!i_stat.out_last) begin
                        n_state = S_OUT_RD;
                    end else if (r_mode) begin
                        // stream closed: rebuild the reset state
                        o_cmd.restart = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_stream_end = r_mode & i_stat.out_last;

endmodule

### hdl/adaptive_arith_encoder16_core.sv
// Sequence: an encode item runs a table lookup and two 32-step divides, shifts out the
//   settled and pending underflow bits, updates the count table from symbol+1 to SYMBOL_COUNT,
//   walks entries 1 to SYMBOL_COUNT again when the table halves, then hands the bytes out.
// Throughput: one item at a time; set by the serial divider and the serial table walk.
// Reset: a clearing pass fills the count table; the same pass runs after each flush.
//   Input is not taken during it; the register port always is.
// ----------------------------------------------------------------------------
// adaptive_arith_encoder16_core
// Adaptive order-0 arithmetic encoder, 16-bit bounds, bytes packed LSB first.
// ----------------------------------------------------------------------------
module adaptive_arith_encoder16_core #(
    parameter int SYMBOL_COUNT = 256,
    parameter int UNDERFLOW_CAP = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    aae16_in_if.sink            i_in,
    aae16_out_if.source         o_out,
    aae16_cfg_if.sink           i_cfg
);
    import aae16_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_valid;
    logic  stream_end;
    logic  in_ready;
    logic [7:0] out_byte;
    logic  sat;

    aae16_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (in_ready),
        .i_mode       (i_in.mode),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (out_valid),
        .o_stream_end (stream_end),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    aae16_dp #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .UNDERFLOW_CAP (UNDERFLOW_CAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_symbol    (i_in.symbol),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.count_increment),
        .o_out_byte  (out_byte),
        .o_sat       (sat)
    );

    assign i_in.ready = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = out_valid;
    assign o_out.out_byte = out_byte;
    assign o_out.last = stat.out_last;
    assign o_out.stream_end = stream_end;
    assign o_out.underflow_saturated = sat;

endmodule

### dv/aae16_checker.sv
// ----------------------------------------------------------------------------
// aae16_checker
// Watches the symbol, byte and register channels of the encoder, keeps its own
// copy of the coder state and checks every coded byte against the prediction.
// ----------------------------------------------------------------------------
module aae16_checker #(
    parameter int SYMBOL_COUNT = 256,
    parameter int UNDERFLOW_CAP = 255
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    aae16_in_if   in_ch,
    aae16_out_if  out_ch,
    aae16_cfg_if  cfg_ch,
    output int    o_fail_count,
    output int    o_bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import aae16_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       stream_end;
        logic       sat;
    } t_coded;

    logic [14:0] cum_tab [0:SYMBOL_COUNT];
    logic [15:0] bound_lo;
    logic [15:0] bound_hi;
    int          underflow_cnt;
    logic [2:0]  pack_pos;
    logic [7:0]  pack_buf;
    logic [6:0]  increment;

    logic [7:0]  item_bytes[$];
    logic        item_sat;
    t_coded      coded_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_bytes_owed = coded_q.size();

    task automatic clear_coder();
        for (int i = 0; i <= SYMBOL_COUNT; i++) begin
            cum_tab[i] = 15'(i);
        end
        bound_lo = '0;
        bound_hi = C_TOP;
        underflow_cnt = 0;
        pack_pos = '0;
        pack_buf = '0;
    endtask

    task automatic put_bit(input logic b);
        pack_buf[pack_pos] = b;
        if (pack_pos == 3'd7) begin
            if (item_bytes.size() < C_MAX_RES) item_bytes.push_back(pack_buf);
            pack_buf = '0;
            pack_pos = '0;
        end else begin
            pack_pos = pack_pos + 3'd1;
        end
    endtask

    task automatic bump_underflow();
        if (underflow_cnt >= UNDERFLOW_CAP) begin
            underflow_cnt = UNDERFLOW_CAP;
            item_sat = 1'b1;
        end else begin
            underflow_cnt++;
        end
    endtask

    task automatic code_symbol(input int sym);
        longint total;
        longint span;
        logic   top;
        logic [14:0] v;
        total = cum_tab[SYMBOL_COUNT];
        if (total == 0) total = 1;
        span = longint'(bound_hi) - longint'(bound_lo) + 1;
        bound_hi = 16'(longint'(bound_lo) + (span * cum_tab[sym + 1]) / total - 1);
        bound_lo = 16'(longint'(bound_lo) + (span * cum_tab[sym]) / total);
        forever begin
            if (bound_hi[15] == bound_lo[15]) begin
                top = bound_hi[15];
                put_bit(top);
                while (underflow_cnt > 0) begin
                    put_bit(!top);
                    underflow_cnt--;
                end
            end else if (bound_lo[14] && !bound_hi[14]) begin
                bump_underflow();
                bound_lo = bound_lo & C_LOW_MASK;
                bound_hi = bound_hi | C_QUARTER;
            end else begin
                break;
            end
            bound_lo = bound_lo << 1;
            bound_hi = (bound_hi << 1) | 16'd1;
        end
        for (int j = sym + 1; j <= SYMBOL_COUNT; j++) begin
            cum_tab[j] = cum_tab[j] + 15'(increment);
        end
        // halve the table, keeping every entry above its neighbor below
        if (cum_tab[SYMBOL_COUNT] >= C_TOTAL_LIMIT) begin
            for (int j = 1; j <= SYMBOL_COUNT; j++) begin
                v = cum_tab[j] >> 1;
                if (v <= cum_tab[j - 1]) v = cum_tab[j - 1] + 15'd1;
                cum_tab[j] = v;
            end
        end
    endtask

    task automatic close_stream();
        logic b;
        b = bound_lo[14];
        put_bit(b);
        bump_underflow();
        while (underflow_cnt > 0) begin
            put_bit(!b);
            underflow_cnt--;
        end
        if (pack_pos != 0 && item_bytes.size() < C_MAX_RES) item_bytes.push_back(pack_buf);
        clear_coder();
    endtask

    task automatic predict_bytes(input logic mode, input logic [7:0] symbol);
        t_coded c;
        int sym;
        item_bytes.delete();
        item_sat = 1'b0;
        if (mode) begin
            close_stream();
        end else begin
            sym = (symbol >= SYMBOL_COUNT) ? SYMBOL_COUNT - 1 : int'(symbol);
            code_symbol(sym);
        end
        foreach (item_bytes[k]) begin
            c.out_byte = item_bytes[k];
            c.last = (k == item_bytes.size() - 1);
            c.stream_end = c.last && mode;
            c.sat = item_sat;
            coded_q.push_back(c);
        end
    endtask

    task automatic check_byte();
        t_coded got;
        t_coded want;
        got = '{out_ch.out_byte, out_ch.last, out_ch.stream_end, out_ch.underflow_saturated};
        if (coded_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected byte %h", got.out_byte);
            return;
        end
        want = coded_q.pop_front();
        if (got !== want) begin
            fails++;
            if (fails <= 10) begin
                $display("byte mismatch: exp byte=%h last=%b end=%b sat=%b",
                         want.out_byte, want.last, want.stream_end, want.sat);
                $display("               got byte=%h last=%b end=%b sat=%b",
                         got.out_byte, got.last, got.stream_end, got.sat);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_coder();
            increment = C_INC_RESET;
            coded_q.delete();
            fails = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) increment = cfg_ch.count_increment;
            if (in_ch.valid && in_ch.ready) predict_bytes(in_ch.mode, in_ch.symbol);
            if (out_ch.valid && out_ch.ready) check_byte();
        end
    end

endmodule

### dv/adaptive_arith_encoder16_core_test.sv
// ----------------------------------------------------------------------------
// adaptive_arith_encoder16_core_test
// Drives symbols, flushes and increment writes into the encoder with random
// gaps and back-pressure; the checker beside the block judges every byte.
// ----------------------------------------------------------------------------
module adaptive_arith_encoder16_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aae16_pkg::*;

    localparam int SETTLE_CYCLES = 1200;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD = 3000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   bytes_owed;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_req;
    int   hold_seen = 0;
    int   hold_left = 0;
    longint cycles = 0;

    aae16_in_if  in_ch();
    aae16_out_if out_ch();
    aae16_cfg_if cfg_ch();

    adaptive_arith_encoder16_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    aae16_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_bytes_owed (bytes_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] symbol);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.symbol <= symbol;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_increment(input logic [6:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.count_increment <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items, input int phase);
        logic [7:0] sym;
        for (int i = 0; i < n_items; i++) begin
            if (phase == 1 && i == 20) hold_req = hold_req + 1;
            if (phase == 2 && i == 40) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (bytes_owed != 0) @(posedge i_clk);
            end
            case ($urandom_range(9))
                0, 1:    sym = 8'($urandom_range(3));
                2:       sym = 8'($urandom_range(255, 250));
                default: sym = 8'($urandom);
            endcase
            if ($urandom_range(24) == 0) send_item(1'b1, 8'($urandom));
            else send_item(1'b0, sym);
        end
    endtask

    initial begin
        logic [7:0] edge_syms[10];
        logic [6:0] incs[5];
        hold_req = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 61;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= 1'b0;
        in_ch.symbol <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.count_increment <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, flushes, empty stream
        edge_syms = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, 8'h00};
        foreach (edge_syms[k]) send_item(1'b0, edge_syms[k]);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h00);
        write_increment(7'd64);
        for (int k = 0; k < 4; k++) send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h5A);
        write_increment(7'd127);
        for (int k = 0; k < 3; k++) send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h00);

        incs = '{7'd1, 7'd64, 7'd0, 7'd10, 7'd37};
        for (int p = 0; p < 5; p++) begin
            write_increment(incs[p]);
            tx_idle_pct = (p < 2) ? 18 : (p < 4) ? 61 : 0;
            rx_idle_pct = (p < 2) ? 61 : (p < 4) ? 18 : 0;
            random_phase(90, p);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && bytes_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
